// File: rtl/extalloc_pkg.sv
// Package for the extent allocator: sizes, codes and transaction types.
`timescale 1ns / 1ps
`default_nettype none

package extalloc_pkg;

   // Table geometry
   localparam int MAX_EXTENTS = 64;
   localparam int IDX_W       = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

   // Field widths
   localparam int PAGE_W  = 16;
   localparam int FREE_W  = 9;
   localparam int COUNT_W = 7;
   localparam int SHIFT_W = 4;

   localparam logic [PAGE_W-1:0]  NO_PAGE     = '1;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(4);
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = SHIFT_W'(8);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_RETURN  = 2'd2,
      CMD_TAKE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_NOT_FOUND  = 2'd1,
      STS_TABLE_FULL = 2'd2,
      STS_SPACE_OUT  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_EXEC
   } state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [PAGE_W-1:0]  page_number;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [PAGE_W-1:0]  start_page;
   } rsp_type;

   // One table slot as stored in the RAM
   typedef struct packed {
      logic [PAGE_W-1:0]  first_page;
      logic [FREE_W-1:0]  free_pages;
   } entry_type;

endpackage

`default_nettype wire

// File: rtl/extalloc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module extalloc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/extent_allocator.sv
// Top level of the extent allocator: command sequencer around the extent table RAM.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_ready  | req_payload (cmd, page_number)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_payload (status, start_page)
//  csr     | in        | csr_valid/csr_ready  | csr_data (extent_shift)
//
// Each transaction passes through an accept state (ST_IDLE), one table RAM read per
// slot (ST_SCAN), a state for the last read to return (ST_LAST) and an update state
// (ST_EXEC). The scan over the table RAM reads one slot per cycle.
// Reset is synchronous; slot valid bits in flip-flops clear at once, so no clearing
// pass is needed. A stalled response holds the update cycle until the output
// register is free; a new request may be taken while a response waits.
`timescale 1ns / 1ps
`default_nettype none

module extent_allocator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire extalloc_pkg::req_type                req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output extalloc_pkg::rsp_type                     rsp_payload,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [extalloc_pkg::SHIFT_W-1:0]     csr_data
);

   import extalloc_pkg::*;

   // Control state
   state_type              state_ff, state_in;
   logic [SHIFT_W-1:0]     shift_ff, shift_in;
   logic [MAX_EXTENTS-1:0] valid_ff, valid_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [PAGE_W-1:0]      next_ff, next_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   hit_ff, hit_in;
   logic                   empty_ff, empty_in;

   // Payload state
   cmd_type                cmd_ff, cmd_in;
   logic [PAGE_W-1:0]      key_ff, key_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]       empty_idx_ff, empty_idx_in;
   entry_type              hit_entry_ff, hit_entry_in;
   rsp_type                rsp_ff, rsp_in;

   // Sequencer outputs
   logic                   accept;
   logic                   scanning;
   logic                   exec_go;

   // RAM port signals
   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   entry_type              ram_wdata;
   entry_type              ram_rdata;

   // Derived extent geometry
   logic [SHIFT_W-1:0]     shift_eff;
   logic [FREE_W-1:0]      ext_size;
   logic [PAGE_W-1:0]      page_mask;

   // Scan compare
   logic [PAGE_W-1:0]      cur_first;
   logic [FREE_W-1:0]      cur_free;
   logic                   cur_used;
   logic                   cur_hit;

   // Update path
   logic [PAGE_W:0]        seg_end;
   logic [FREE_W-1:0]      f_val;

   extalloc_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_EXTENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rdata)
   );

   // Extent size, clamped at 2^8 pages
   always_comb begin
      shift_eff = (shift_ff > SHIFT_MAX) ? SHIFT_MAX : shift_ff;
      ext_size  = FREE_W'(1) << shift_eff;
      page_mask = PAGE_W'(ext_size - FREE_W'(1));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == IDX_W'(MAX_EXTENTS - 1)) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      scanning  = 1'b0;
      exec_go   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SCAN: begin
            scanning = 1'b1;
         end
         ST_LAST: begin
         end
         ST_EXEC: begin
            exec_go = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Entry returned by the RAM; slots never written read as unused
   always_comb begin
      cur_first = rd_valid_ff ? ram_rdata.first_page : NO_PAGE;
      cur_free  = rd_valid_ff ? ram_rdata.free_pages : '0;
      cur_used  = (cur_first != NO_PAGE);
      if (cmd_ff == CMD_ALLOC) begin
         cur_hit = cur_used && (cur_free == ext_size) && (count_ff != '0);
      end else begin
         cur_hit = cur_used && (cur_first == key_ff);
      end
   end

   // Scan bookkeeping: first match and first unused slot
   always_comb begin
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      scan_idx_in  = scan_idx_ff;
      rd_vld_in    = scanning;
      rd_idx_in    = scan_idx_ff;
      rd_valid_in  = valid_ff[scan_idx_ff];
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_entry_in = hit_entry_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;

      if (accept) begin
         cmd_in      = req_payload.cmd;
         key_in      = (req_payload.cmd == CMD_RELEASE) ? req_payload.page_number
                                                        : (req_payload.page_number & ~page_mask);
         scan_idx_in = '0;
         hit_in      = 1'b0;
         empty_in    = 1'b0;
      end else if (scanning && (scan_idx_ff != IDX_W'(MAX_EXTENTS - 1))) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end

      if (rd_vld_ff) begin
         if (cur_hit && !hit_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = rd_idx_ff;
            hit_entry_in = '{first_page: cur_first, free_pages: cur_free};
         end
         if (!cur_used && !empty_ff) begin
            empty_in     = 1'b1;
            empty_idx_in = rd_idx_ff;
         end
      end
   end

   // Command update: table write, counters and response
   always_comb begin
      valid_in     = valid_ff;
      count_in     = count_ff;
      next_in      = next_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      shift_in     = (csr_valid && csr_ready) ? csr_data : shift_ff;
      ram_we       = 1'b0;
      ram_waddr    = hit_idx_ff;
      ram_wdata    = hit_entry_ff;
      seg_end      = {1'b0, next_ff} + (PAGE_W + 1)'(ext_size);
      f_val        = hit_entry_ff.free_pages;

      if (exec_go) begin
         rsp_valid_in      = 1'b1;
         rsp_in.status     = STS_OK;
         rsp_in.start_page = '0;
         if (cmd_ff == CMD_ALLOC) begin
            if (hit_ff) begin
               // Reuse the first wholly free extent
               ram_we               = 1'b1;
               ram_wdata.free_pages = ext_size - FREE_W'(1);
               count_in             = count_ff - COUNT_W'(1);
               rsp_in.start_page    = hit_entry_ff.first_page;
            end else if (!empty_ff) begin
               rsp_in.status = STS_TABLE_FULL;
            end else if (seg_end > {1'b0, NO_PAGE}) begin
               rsp_in.status = STS_SPACE_OUT;
            end else begin
               // Open a new extent at the segment end
               ram_we                  = 1'b1;
               ram_waddr               = empty_idx_ff;
               ram_wdata.first_page    = next_ff;
               ram_wdata.free_pages    = ext_size - FREE_W'(1);
               valid_in[empty_idx_ff]  = 1'b1;
               next_in                 = seg_end[PAGE_W-1:0];
               rsp_in.start_page       = next_ff;
            end
         end else if (!hit_ff) begin
            rsp_in.status = STS_NOT_FOUND;
         end else begin
            rsp_in.start_page = key_ff;
            case (cmd_ff)
               CMD_RELEASE: begin
                  if (f_val != ext_size) begin
                     ram_we               = 1'b1;
                     ram_wdata.free_pages = ext_size;
                     if (count_ff != COUNT_MAX) begin
                        count_in = count_ff + COUNT_W'(1);
                     end
                  end
               end
               CMD_RETURN: begin
                  if (f_val < ext_size) begin
                     ram_we               = 1'b1;
                     ram_wdata.free_pages = f_val + FREE_W'(1);
                     if ((f_val + FREE_W'(1) == ext_size) && (count_ff != COUNT_MAX)) begin
                        count_in = count_ff + COUNT_W'(1);
                     end
                  end
               end
               CMD_TAKE: begin
                  if (f_val != '0) begin
                     ram_we               = 1'b1;
                     ram_wdata.free_pages = f_val - FREE_W'(1);
                     if ((f_val == ext_size) && (count_ff != '0)) begin
                        count_in = count_ff - COUNT_W'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shift_ff     <= SHIFT_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         next_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         scan_idx_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         empty_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         next_ff      <= next_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_idx_ff  <= scan_idx_in;
         rd_vld_ff    <= rd_vld_in;
         rd_valid_ff  <= rd_valid_in;
         hit_ff       <= hit_in;
         empty_ff     <= empty_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      rd_idx_ff    <= rd_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      empty_idx_ff <= empty_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Table writes happen only in the update cycle
   a_write_in_exec : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_EXEC))
      else $error("table write outside update cycle");

   // A write goes to the matched slot or claims an unused one
   a_write_target : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (hit_ff || !valid_ff[ram_waddr]))
      else $error("table write to unexpected slot");

   // Read data is compared only while a scan is running
   a_read_in_scan : assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ((state_ff == ST_SCAN) || (state_ff == ST_LAST)))
      else $error("stray table read");

   // The segment end never moves back
   a_segment_grows : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (next_ff >= $past(next_ff)))
      else $error("segment end moved back");

endmodule

`default_nettype wire
